// ===== rtl/rpn_pkg.sv =====
// Shared types, codes and the microcode ROM of the RPN stack evaluator.
// No dependencies; imported by rpn_stack_evaluator_top.
package rpn_pkg;

    localparam int VAL_W  = 64;
    localparam int NUM_W  = 31;
    localparam int CMD_W  = 3;
    localparam int STAT_W = 3;
    localparam int UPC_W  = 4;
    localparam int CNT_W  = 6;

    // token classes, as carried in the input and output tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_NUM     = 3'd0,
        CMD_ADD     = 3'd1,
        CMD_SUB     = 3'd2,
        CMD_MUL     = 3'd3,
        CMD_DIV     = 3'd4,
        CMD_INVALID = 3'd5,
        CMD_FINISH  = 3'd6
    } t_cmd;

    localparam logic [CMD_W-1:0] CMD_RAW_SPARE = 3'd7;

    typedef enum logic [STAT_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_CHAR  = 3'd1,
        ST_DIV_ZERO  = 3'd2,
        ST_UNDERFLOW = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_HALTED    = 3'd5,
        ST_BAD_DEPTH = 3'd6
    } t_status;

    // datapath action of one microcode step
    typedef enum logic [3:0] {
        U_NOP,
        U_FETCH,
        U_CHECK,
        U_MAG,
        U_ADDSUB,
        U_MULP,
        U_MULA,
        U_MULSAT,
        U_DIVINIT,
        U_DIVSTEP,
        U_DIVSAT,
        U_COMMIT,
        U_RESP
    } t_uop;

    // jump condition of one microcode step
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NO_BEAT,
        C_NOT_ARITH,
        C_IS_MUL,
        C_IS_DIV,
        C_CNT_NZ,
        C_DIV_OVF,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_uop             op;
        t_cond            cond;
        logic [UPC_W-1:0] target;
    } t_uword;

    localparam logic [UPC_W-1:0] UPC_FETCH   = 4'd0;
    localparam logic [UPC_W-1:0] UPC_CHECK   = 4'd1;
    localparam logic [UPC_W-1:0] UPC_MAG     = 4'd2;
    localparam logic [UPC_W-1:0] UPC_DISP    = 4'd3;
    localparam logic [UPC_W-1:0] UPC_ADDSUB  = 4'd4;
    localparam logic [UPC_W-1:0] UPC_MULP    = 4'd5;
    localparam logic [UPC_W-1:0] UPC_MULA    = 4'd6;
    localparam logic [UPC_W-1:0] UPC_MULSAT  = 4'd7;
    localparam logic [UPC_W-1:0] UPC_DIVINIT = 4'd8;
    localparam logic [UPC_W-1:0] UPC_DIVSTEP = 4'd9;
    localparam logic [UPC_W-1:0] UPC_DIVSAT  = 4'd10;
    localparam logic [UPC_W-1:0] UPC_COMMIT  = 4'd11;
    localparam logic [UPC_W-1:0] UPC_RESP    = 4'd12;
    localparam logic [UPC_W-1:0] UPC_RWAIT   = 4'd13;

    // Microcode ROM: taken jump goes to target, otherwise fall through to pc + 1
    function automatic t_uword ucode(input logic [UPC_W-1:0] pc);
        t_uword w;
        w = '{op: U_NOP, cond: C_ALWAYS, target: UPC_FETCH};
        case (pc)
            UPC_FETCH:   w = '{op: U_FETCH,   cond: C_NO_BEAT,   target: UPC_FETCH};
            UPC_CHECK:   w = '{op: U_CHECK,   cond: C_NOT_ARITH, target: UPC_RESP};
            UPC_MAG:     w = '{op: U_MAG,     cond: C_IS_MUL,    target: UPC_MULP};
            UPC_DISP:    w = '{op: U_NOP,     cond: C_IS_DIV,    target: UPC_DIVINIT};
            UPC_ADDSUB:  w = '{op: U_ADDSUB,  cond: C_ALWAYS,    target: UPC_COMMIT};
            UPC_MULP:    w = '{op: U_MULP,    cond: C_ALWAYS,    target: UPC_MULA};
            UPC_MULA:    w = '{op: U_MULA,    cond: C_CNT_NZ,    target: UPC_MULP};
            UPC_MULSAT:  w = '{op: U_MULSAT,  cond: C_ALWAYS,    target: UPC_COMMIT};
            UPC_DIVINIT: w = '{op: U_DIVINIT, cond: C_DIV_OVF,   target: UPC_DIVSAT};
            UPC_DIVSTEP: w = '{op: U_DIVSTEP, cond: C_CNT_NZ,    target: UPC_DIVSTEP};
            UPC_DIVSAT:  w = '{op: U_DIVSAT,  cond: C_ALWAYS,    target: UPC_COMMIT};
            UPC_COMMIT:  w = '{op: U_COMMIT,  cond: C_ALWAYS,    target: UPC_RESP};
            UPC_RESP:    w = '{op: U_RESP,    cond: C_OUT_FREE,  target: UPC_FETCH};
            UPC_RWAIT:   w = '{op: U_NOP,     cond: C_ALWAYS,    target: UPC_RESP};
            default:     w = '{op: U_NOP,     cond: C_ALWAYS,    target: UPC_FETCH};
        endcase
        return w;
    endfunction

    // unsigned magnitude of a two's complement value (most negative stays 2^63)
    function automatic logic [VAL_W-1:0] magnitude(input logic [VAL_W-1:0] x);
        return x[VAL_W-1] ? (VAL_W'(0) - x) : x;
    endfunction

    // apply a sign to a magnitude, saturating to the signed range
    function automatic logic [VAL_W-1:0] sign_sat(input logic neg,
                                                  input logic [VAL_W-1:0] mag,
                                                  input logic ovf);
        logic [VAL_W-1:0] min_mag;
        logic [VAL_W-1:0] res;
        min_mag = {1'b1, {(VAL_W-1){1'b0}}};
        if (neg) begin
            res = (ovf || mag > min_mag) ? min_mag : (VAL_W'(0) - mag);
        end else begin
            res = (ovf || mag[VAL_W-1]) ? {1'b0, {(VAL_W-1){1'b1}}} : mag;
        end
        return res;
    endfunction

endpackage

// ===== rtl/rpn_stack_evaluator_top.sv =====
// RPN stack evaluator: microcoded sequencer, Q-format datapath and value stack.
// Depends on rpn_pkg.
//
// Takes one token per input beat (tuser = class, tdata = number) and returns one
// result beat per token. The block works on one token at a time; the input is
// ready only while the sequencer sits in its fetch step, and a finished result
// waits in the output register while the next token is taken in. A multiply
// forms four 32x32 partial products, one per pair of steps; a divide yields one
// quotient bit per cycle, or skips the quotient steps when the quotient
// saturates early. No clearing pass after reset: the stack memory holds only
// entries below the current depth. Any error halts the block until reset;
// halted tokens report status "halted" and leave the stack unchanged.
module rpn_stack_evaluator_top #(
    parameter int STACK_DEPTH   = 64,
    parameter int FRACTION_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input token stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [30:0] number_value, [31] zero
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] command
    // result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [71:0] o_m_axis_tdata,   // [2:0] status, [66:3] top_value,
                                          // [67] final_valid, [71:68] zero
    output logic [2:0]  o_m_axis_tuser    // [2:0] token_class
);
    import rpn_pkg::*;

    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int PROD_W  = 2 * VAL_W;
    localparam int HALF_W  = VAL_W / 2;

    // sequencer
    logic [UPC_W-1:0]  r_upc;
    logic [UPC_W-1:0]  n_upc;
    t_uword            uw;
    logic              cond_hit;

    // control state
    logic [DEPTH_W-1:0] r_depth;
    logic               r_halted;
    logic               r_o_valid;

    // token and datapath registers
    t_cmd               r_cls;
    logic [NUM_W-1:0]   r_num;
    t_status            r_status;
    logic               r_fin;
    logic [VAL_W-1:0]   r_top;
    logic [VAL_W-1:0]   r_rd;
    logic [VAL_W-1:0]   r_a;
    logic [VAL_W-1:0]   r_b;
    logic [VAL_W-1:0]   r_ma;
    logic [VAL_W-1:0]   r_mb;
    logic               r_neg;
    logic [VAL_W-1:0]   r_res;
    logic [VAL_W-1:0]   r_pp;
    logic [PROD_W-1:0]  r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic [VAL_W-1:0]   r_rem;
    logic [VAL_W-1:0]   r_dq;
    logic               r_dovf;

    // output register payload
    t_cmd               r_o_cls;
    t_status            r_o_status;
    logic [VAL_W-1:0]   r_o_top;
    logic               r_o_fin;

    // value stack below the top register
    logic [VAL_W-1:0]   mem [STACK_DEPTH];

    // combinational helpers
    logic               in_beat;
    logic               out_free;
    t_cmd               in_cls;
    t_status            chk_status;
    logic               chk_arith;
    logic               chk_push;
    logic               chk_fin;
    logic [DEPTH_W-1:0] depth_m1;
    logic [DEPTH_W-1:0] depth_m2;
    logic [ADDR_W-1:0]  wr_idx;
    logic [ADDR_W-1:0]  rd_idx;
    logic [VAL_W-1:0]   push_val;
    logic [VAL_W-1:0]   add_sum;
    logic [VAL_W-1:0]   sub_dif;
    logic [VAL_W-1:0]   add_sat;
    logic [VAL_W-1:0]   sub_sat;
    logic [HALF_W-1:0]  mul_x;
    logic [HALF_W-1:0]  mul_y;
    logic [PROD_W-1:0]  mul_term;
    logic [PROD_W-1:0]  mul_shr;
    logic [PROD_W-1:0]  div_wide;
    logic [VAL_W-1:0]   div_rr;
    logic               div_ge;

    assign uw       = ucode(r_upc);
    assign in_beat  = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free = !r_o_valid || i_m_axis_tready;

    // fold the spare command code into the invalid class
    assign in_cls = (i_s_axis_tuser == CMD_RAW_SPARE) ? CMD_INVALID : t_cmd'(i_s_axis_tuser);

    assign depth_m1 = r_depth - DEPTH_W'(1);
    assign depth_m2 = r_depth - DEPTH_W'(2);
    assign wr_idx   = depth_m1[ADDR_W-1:0];
    assign rd_idx   = depth_m2[ADDR_W-1:0];
    assign push_val = VAL_W'(r_num) << FRACTION_BITS;

    // classify the token against depth and halt state
    always_comb begin
        chk_status = ST_OK;
        chk_arith  = 1'b0;
        chk_push   = 1'b0;
        chk_fin    = 1'b0;
        if (r_halted) begin
            chk_status = ST_HALTED;
        end else begin
            case (r_cls) inside
                CMD_NUM: begin
                    if (r_depth >= DEPTH_W'(STACK_DEPTH)) chk_status = ST_OVERFLOW;
                    else chk_push = 1'b1;
                end
                CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                    if (r_depth < DEPTH_W'(2)) chk_status = ST_UNDERFLOW;
                    else if (r_cls == CMD_DIV && r_top == '0) chk_status = ST_DIV_ZERO;
                    else chk_arith = 1'b1;
                end
                CMD_FINISH: begin
                    if (r_depth == DEPTH_W'(1)) chk_fin = 1'b1;
                    else chk_status = ST_BAD_DEPTH;
                end
                default: chk_status = ST_BAD_CHAR;
            endcase
        end
    end

    // saturating add and subtract
    always_comb begin
        add_sum = r_a + r_b;
        sub_dif = r_a - r_b;
        add_sat = add_sum;
        sub_sat = sub_dif;
        if (r_a[VAL_W-1] == r_b[VAL_W-1] && add_sum[VAL_W-1] != r_a[VAL_W-1]) begin
            add_sat = r_a[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
        if (r_a[VAL_W-1] != r_b[VAL_W-1] && sub_dif[VAL_W-1] != r_a[VAL_W-1]) begin
            sub_sat = r_a[VAL_W-1] ? {1'b1, {(VAL_W-1){1'b0}}} : {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    // partial product select: counter bit 1 picks the half of a, bit 0 the half of b
    assign mul_x    = r_cnt[1] ? r_ma[VAL_W-1:HALF_W] : r_ma[HALF_W-1:0];
    assign mul_y    = r_cnt[0] ? r_mb[VAL_W-1:HALF_W] : r_mb[HALF_W-1:0];
    assign mul_term = PROD_W'(r_pp) << (HALF_W * (32'(r_cnt[1]) + 32'(r_cnt[0])));
    assign mul_shr  = r_acc >> FRACTION_BITS;

    // restoring divide: dividend is |a| << FRACTION_BITS, high half seeds the remainder
    assign div_wide = PROD_W'(r_ma) << FRACTION_BITS;
    assign div_rr   = {r_rem[VAL_W-2:0], r_dq[VAL_W-1]};
    assign div_ge   = div_rr >= r_mb;

    // jump condition
    always_comb begin
        case (uw.cond)
            C_ALWAYS:    cond_hit = 1'b1;
            C_NO_BEAT:   cond_hit = !in_beat;
            C_NOT_ARITH: cond_hit = !chk_arith;
            C_IS_MUL:    cond_hit = (r_cls == CMD_MUL);
            C_IS_DIV:    cond_hit = (r_cls == CMD_DIV);
            C_CNT_NZ:    cond_hit = (r_cnt != '0);
            C_DIV_OVF:   cond_hit = (div_wide[PROD_W-1:VAL_W] >= r_mb);
            C_OUT_FREE:  cond_hit = out_free;
            default:     cond_hit = 1'b1;
        endcase
    end

    assign n_upc = cond_hit ? uw.target : (r_upc + UPC_W'(1));

    // control state: step counter, depth, halt flag, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc     <= UPC_FETCH;
            r_depth   <= '0;
            r_halted  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_upc <= n_upc;
            if (uw.op == U_CHECK) begin
                if (chk_push) r_depth <= r_depth + DEPTH_W'(1);
                if (chk_status != ST_OK && chk_status != ST_HALTED) r_halted <= 1'b1;
            end
            if (uw.op == U_COMMIT) r_depth <= depth_m1;
            if (uw.op == U_RESP && out_free) r_o_valid <= 1'b1;
            else if (i_m_axis_tready) r_o_valid <= 1'b0;
        end
    end

    // stack memory: spill the old top on a push, read the second entry every cycle
    always_ff @(posedge i_clk) begin
        if (uw.op == U_CHECK && chk_push && r_depth != '0) mem[wr_idx] <= r_top;
        r_rd <= mem[rd_idx];
    end

    // datapath driven by the current control word
    always_ff @(posedge i_clk) begin
        unique case (uw.op)
            U_FETCH: begin
                if (in_beat) begin
                    r_cls <= in_cls;
                    r_num <= i_s_axis_tdata[NUM_W-1:0];
                end
            end
            U_CHECK: begin
                r_status <= chk_status;
                r_fin    <= chk_fin;
                r_a      <= r_rd;
                r_b      <= r_top;
                if (chk_push) r_top <= push_val;
            end
            U_MAG: begin
                r_ma  <= magnitude(r_a);
                r_mb  <= magnitude(r_b);
                r_neg <= r_a[VAL_W-1] ^ r_b[VAL_W-1];
                r_acc <= '0;
                r_cnt <= CNT_W'(3);
            end
            U_ADDSUB: begin
                r_res <= (r_cls == CMD_SUB) ? sub_sat : add_sat;
            end
            U_MULP: begin
                r_pp <= VAL_W'(mul_x) * VAL_W'(mul_y);
            end
            U_MULA: begin
                r_acc <= r_acc + mul_term;
                r_cnt <= r_cnt - CNT_W'(1);
            end
            U_MULSAT: begin
                r_res <= sign_sat(r_neg, mul_shr[VAL_W-1:0], |mul_shr[PROD_W-1:VAL_W]);
            end
            U_DIVINIT: begin
                r_rem  <= div_wide[PROD_W-1:VAL_W];
                r_dq   <= div_wide[VAL_W-1:0];
                r_dovf <= div_wide[PROD_W-1:VAL_W] >= r_mb;
                r_cnt  <= CNT_W'(VAL_W - 1);
            end
            U_DIVSTEP: begin
                r_rem <= div_ge ? (div_rr - r_mb) : div_rr;
                r_dq  <= {r_dq[VAL_W-2:0], div_ge};
                r_cnt <= r_cnt - CNT_W'(1);
            end
            U_DIVSAT: begin
                r_res <= sign_sat(r_neg, r_dq, r_dovf);
            end
            U_COMMIT: begin
                r_top <= r_res;
            end
            U_RESP: begin
                if (out_free) begin
                    r_o_cls    <= r_cls;
                    r_o_status <= r_status;
                    r_o_top    <= (r_depth == '0) ? '0 : r_top;
                    r_o_fin    <= r_fin;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_s_axis_tready = (uw.op == U_FETCH);
    assign o_m_axis_tvalid = r_o_valid;
    assign o_m_axis_tuser  = r_o_cls;
    assign o_m_axis_tdata  = {4'b0, r_o_fin, r_o_top, r_o_status};

endmodule
